// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: post must hold whenever pre holds.
`define BPPI_ASSERT_NOW(label, clk, dis, pre, post) \
    label: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication: post must hold in the cycle after pre.
`define BPPI_ASSERT_NEXT(label, clk, dis, pre, post) \
    label: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
        else $error("next-cycle assertion failed");

`endif

// ===== rtl/core/bppi_pkg.sv =====
// Types and constants of the beam path position interpolator.
`default_nettype none

package bppi_pkg;

    // Field widths.
    localparam int SEG_W  = 10;
    localparam int POS_W  = 32;
    localparam int PWR_W  = 16;
    localparam int TIME_W = 48;

    // Input item layout in s_tdata, lowest bit first.
    localparam int S_IDX_LSB   = 0;
    localparam int S_MODE_LSB  = S_IDX_LSB + SEG_W;
    localparam int S_X_LSB     = S_MODE_LSB + 1;
    localparam int S_Y_LSB     = S_X_LSB + POS_W;
    localparam int S_Z_LSB     = S_Y_LSB + POS_W;
    localparam int S_PWR_LSB   = S_Z_LSB + POS_W;
    localparam int S_END_LSB   = S_PWR_LSB + PWR_W;
    localparam int S_QT_LSB    = S_END_LSB + TIME_W;
    localparam int S_START_LSB = S_QT_LSB + TIME_W;
    localparam int S_USED_W    = S_START_LSB + SEG_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Result item layout in m_tdata, lowest bit first.
    localparam int M_X_LSB    = 0;
    localparam int M_Y_LSB    = M_X_LSB + POS_W;
    localparam int M_Z_LSB    = M_Y_LSB + POS_W;
    localparam int M_PWR_LSB  = M_Z_LSB + POS_W;
    localparam int M_SEG_LSB  = M_PWR_LSB + PWR_W;
    localparam int M_USED_W   = M_SEG_LSB + SEG_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // Interpolation arithmetic: |elapsed| * |delta| fits 48 + 32 bits.
    localparam int UE_W    = TIME_W;
    localparam int UD_W    = POS_W;
    localparam int PROD_W  = UE_W + UD_W;
    localparam int HALF_W  = UE_W / 2;
    localparam int MULP_W  = HALF_W + UD_W;
    localparam int QMAG_W  = 41;
    localparam int SUM_W   = QMAG_W + 2;
    localparam int DCNT_W  = $clog2(PROD_W);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(PROD_W - 1);
    localparam logic [QMAG_W-1:0] QCAP     = {1'b1, {(QMAG_W-1){1'b0}}};

    // Axis counter.
    localparam int AXES   = 3;
    localparam int AXIS_W = 2;
    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    // Item kind carried in s_tuser.
    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    localparam logic MODE_SPOT = 1'b1;

    // One table entry as stored in the segment memory.
    typedef struct packed {
        logic [TIME_W-1:0]       end_time;
        logic [PWR_W-1:0]        power;
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
        logic                    mode;
    } seg_entry_t;

    // Query sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREV_RD,
        ST_PREV_CHK,
        ST_CUR_RD,
        ST_CUR_CHK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/beam_path_position_interpolator_top.sv =====
// Beam path position interpolator: segment table, backward walk and serial interpolation.
//
// Usage: s_* carries items in; s_tuser selects a write (0) or a query (1).
// A write stores one segment entry in the table and returns nothing; the next
// item can follow at once. A query walks backward from its start segment, each
// backward step being one table read and one compare. For any line segment of
// nonzero duration it then interpolates x, y and z one axis after another on a
// single shared datapath: a 24 x 32 multiplier used twice and a radix-2
// restoring divider over the 80-bit product. A spot segment or a zero-duration
// line segment skips that arithmetic. The result appears in the same cycle in
// which the block is ready again, and the block takes no new item while a
// query is in flight.
// Results leave through an output register on m_*. While the receiver stalls,
// the result holds and a finished query waits in its last state; once the
// register is free the block is ready again, so a new item is taken while the
// previous result still waits. Reset clears the sequencer and the output valid
// and holds s_tready low; the table itself is not cleared, and entries must be
// written before use.
`default_nettype none

module beam_path_position_interpolator_top #(
    parameter int SEGMENTS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // seg_index, seg_mode, seg_x, seg_y, seg_z, seg_power, seg_end_time,
    // query_time, start_segment
    input  logic [bppi_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // beam_x, beam_y, beam_z, beam_power, found_segment
    output logic [bppi_pkg::M_TDATA_W-1:0] m_tdata
);

    import bppi_pkg::*;

    localparam int IDX_W = $clog2(SEGMENTS);

    // Input field unpacking.
    func_t                in_func;
    logic [SEG_W-1:0]     in_seg_index;
    logic [SEG_W-1:0]     in_start;
    logic [TIME_W-1:0]    in_query_time;
    seg_entry_t           wr_entry;

    assign in_func       = func_t'(s_tuser);
    assign in_seg_index  = s_tdata[S_IDX_LSB +: SEG_W];
    assign in_start      = s_tdata[S_START_LSB +: SEG_W];
    assign in_query_time = s_tdata[S_QT_LSB +: TIME_W];
    assign wr_entry.mode     = s_tdata[S_MODE_LSB];
    assign wr_entry.x        = s_tdata[S_X_LSB +: POS_W];
    assign wr_entry.y        = s_tdata[S_Y_LSB +: POS_W];
    assign wr_entry.z        = s_tdata[S_Z_LSB +: POS_W];
    assign wr_entry.power    = s_tdata[S_PWR_LSB +: PWR_W];
    assign wr_entry.end_time = s_tdata[S_END_LSB +: TIME_W];

    // Registers.
    state_t                  state_reg, state_next;
    logic [SEG_W-1:0]        seg_reg;
    logic [TIME_W-1:0]       t_reg;
    logic [TIME_W-1:0]       prev_end_reg;
    logic signed [POS_W-1:0] prev_pos_reg [AXES];
    logic signed [POS_W-1:0] cur_pos_reg  [AXES];
    logic signed [POS_W-1:0] res_pos_reg  [AXES];
    logic [PWR_W-1:0]        power_reg;
    logic [UE_W-1:0]         ue_reg;
    logic [UE_W-1:0]         udur_reg;
    logic                    neg_time_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [UE_W-1:0]         rem_reg;
    logic [DCNT_W-1:0]       div_cnt_reg;
    logic [AXIS_W-1:0]       axis_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    seg_entry_t              rd_data_reg;

    // Segment memory.
    seg_entry_t seg_mem [SEGMENTS];

    // Control signals.
    logic              s_accept;
    logic              mem_we;
    logic [IDX_W-1:0]  rd_addr;
    logic [SEG_W-1:0]  seg_minus1;
    logic              walk_back;
    logic              out_free;
    logic [SEG_W-1:0]  start_clamped;

    // Arithmetic signals.
    logic signed [TIME_W:0]  elapsed;
    logic signed [TIME_W:0]  duration;
    logic                    dur_zero;
    logic signed [POS_W-1:0] prev_a;
    logic signed [POS_W-1:0] cur_a;
    logic signed [POS_W:0]   diff;
    logic [UD_W-1:0]         ud;
    logic [HALF_W-1:0]       mul_a;
    logic [MULP_W-1:0]       mul_p;
    logic [UE_W:0]           rem_sh;
    logic [UE_W:0]           rem_sub;
    logic                    div_ge;
    logic [QMAG_W-1:0]       q_mag;
    logic signed [SUM_W-1:0] q_signed;
    logic signed [SUM_W-1:0] sum;
    logic signed [POS_W-1:0] sum_sat;

    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign seg_minus1 = seg_reg - SEG_W'(1);
    assign walk_back  = (seg_reg > SEG_W'(1)) && (t_reg < rd_data_reg.end_time);

    // Start segment clamp into the valid range.
    always_comb begin
        if (in_start == '0) begin
            start_clamped = SEG_W'(1);
        end else if (int'(in_start) > SEGMENTS - 1) begin
            start_clamped = SEG_W'(SEGMENTS - 1);
        end else begin
            start_clamped = in_start;
        end
    end

    // Sequencer outputs: handshake, memory port.
    always_comb begin
        s_tready = aresetn && (state_reg == ST_IDLE);
        mem_we   = s_accept && (in_func == FUNC_WRITE) && (int'(in_seg_index) < SEGMENTS);
        case (state_reg)
            ST_PREV_RD: rd_addr = IDX_W'(seg_minus1);
            default:    rd_addr = IDX_W'(seg_reg);
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_func == FUNC_QUERY) begin
                    state_next = ST_PREV_RD;
                end
            end
            ST_PREV_RD:  state_next = ST_PREV_CHK;
            ST_PREV_CHK: state_next = walk_back ? ST_PREV_RD : ST_CUR_RD;
            ST_CUR_RD:   state_next = ST_CUR_CHK;
            ST_CUR_CHK: begin
                if (rd_data_reg.mode == MODE_SPOT || dur_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_DIV;
            ST_DIV:    state_next = (div_cnt_reg == DIV_LAST) ? ST_ACC : ST_DIV;
            ST_ACC:    state_next = (axis_reg == LAST_AXIS) ? ST_DONE : ST_MUL_LO;
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Elapsed time and duration of the found segment, with their magnitudes.
    assign elapsed  = $signed({1'b0, t_reg}) - $signed({1'b0, prev_end_reg});
    assign duration = $signed({1'b0, rd_data_reg.end_time}) - $signed({1'b0, prev_end_reg});
    assign dur_zero = (duration == '0);

    // Per-axis delta magnitude.
    assign prev_a = prev_pos_reg[axis_reg];
    assign cur_a  = cur_pos_reg[axis_reg];
    assign diff   = $signed({cur_a[POS_W-1], cur_a}) - $signed({prev_a[POS_W-1], prev_a});
    assign ud     = diff[POS_W] ? UD_W'(-diff) : UD_W'(diff);

    // Shared multiplier: low half of |elapsed| first, then the high half.
    assign mul_a = (state_reg == ST_MUL_LO) ? ue_reg[HALF_W-1:0] : ue_reg[UE_W-1:HALF_W];
    assign mul_p = mul_a * ud;

    // One restoring division step.
    assign rem_sh  = {rem_reg, prod_reg[PROD_W-1]};
    assign rem_sub = rem_sh - {1'b0, udur_reg};
    assign div_ge  = (rem_sh >= {1'b0, udur_reg});

    // Quotient cap, sign and saturating accumulate onto the previous point.
    always_comb begin
        if (prod_reg > PROD_W'(QCAP)) begin
            q_mag = QCAP;
        end else begin
            q_mag = prod_reg[QMAG_W-1:0];
        end
        q_signed = neg_reg ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
        sum      = $signed({{(SUM_W-POS_W){prev_a[POS_W-1]}}, prev_a}) + q_signed;
        if (sum[SUM_W-1:POS_W-1] == {(SUM_W-POS_W+1){sum[POS_W-1]}}) begin
            sum_sat = sum[POS_W-1:0];
        end else if (sum[SUM_W-1]) begin
            sum_sat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    // Segment memory: one write port for write items, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seg_mem[IDX_W'(in_seg_index)] <= wr_entry;
        end
        rd_data_reg <= seg_mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Query datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_func == FUNC_QUERY) begin
                    t_reg   <= in_query_time;
                    seg_reg <= start_clamped;
                end
            end
            ST_PREV_CHK: begin
                if (walk_back) begin
                    seg_reg <= seg_minus1;
                end else begin
                    prev_pos_reg[0] <= rd_data_reg.x;
                    prev_pos_reg[1] <= rd_data_reg.y;
                    prev_pos_reg[2] <= rd_data_reg.z;
                    prev_end_reg    <= rd_data_reg.end_time;
                end
            end
            ST_CUR_CHK: begin
                cur_pos_reg[0] <= rd_data_reg.x;
                cur_pos_reg[1] <= rd_data_reg.y;
                cur_pos_reg[2] <= rd_data_reg.z;
                power_reg      <= rd_data_reg.power;
                ue_reg         <= elapsed[TIME_W] ? UE_W'(-elapsed) : UE_W'(elapsed);
                udur_reg       <= duration[TIME_W] ? UE_W'(-duration) : UE_W'(duration);
                neg_time_reg   <= elapsed[TIME_W] ^ duration[TIME_W];
                axis_reg       <= '0;
                if (rd_data_reg.mode == MODE_SPOT) begin
                    res_pos_reg[0] <= rd_data_reg.x;
                    res_pos_reg[1] <= rd_data_reg.y;
                    res_pos_reg[2] <= rd_data_reg.z;
                end else begin
                    res_pos_reg[0] <= prev_pos_reg[0];
                    res_pos_reg[1] <= prev_pos_reg[1];
                    res_pos_reg[2] <= prev_pos_reg[2];
                end
            end
            ST_MUL_LO: begin
                prod_reg <= PROD_W'(mul_p);
                neg_reg  <= neg_time_reg ^ diff[POS_W];
            end
            ST_MUL_HI: begin
                prod_reg    <= prod_reg + {mul_p, {HALF_W{1'b0}}};
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV: begin
                rem_reg     <= div_ge ? rem_sub[UE_W-1:0] : rem_sh[UE_W-1:0];
                prod_reg    <= {prod_reg[PROD_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
            end
            ST_ACC: begin
                res_pos_reg[axis_reg] <= sum_sat;
                axis_reg              <= axis_reg + AXIS_W'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {{(M_TDATA_W-M_USED_W){1'b0}}, seg_reg, power_reg,
                                    res_pos_reg[2], res_pos_reg[1], res_pos_reg[0]};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bppi_checker.sv =====
// Port-level checker for the beam path position interpolator, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module bppi_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [bppi_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bppi_pkg::M_TDATA_W-1:0] m_tdata
);

    import bppi_pkg::*;

    logic write_acc;
    logic query_acc;

    assign write_acc = s_tvalid && s_tready && (func_t'(s_tuser) == FUNC_WRITE);
    assign query_acc = s_tvalid && s_tready && (func_t'(s_tuser) == FUNC_QUERY);

    // A stalled result keeps its valid and its data.
    `BPPI_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The first cycle out of reset shows no result.
    `BPPI_ASSERT_NOW(a_reset_no_out, aclk, !aresetn, !$past(aresetn), !m_tvalid)

    // A query keeps the block busy in the following cycle.
    `BPPI_ASSERT_NEXT(a_query_busy, aclk, !aresetn, query_acc, !s_tready)

    // A write leaves the block ready in the following cycle.
    `BPPI_ASSERT_NEXT(a_write_ready, aclk, !aresetn, write_acc, s_tready)

    // The walk never ends on segment zero.
    `BPPI_ASSERT_NOW(a_found_nonzero, aclk, !aresetn, m_tvalid, m_tdata[M_SEG_LSB +: SEG_W] != '0)

endmodule

bind beam_path_position_interpolator_top bppi_checker u_bppi_checker (.*);

`default_nettype wire
